// ----- src/rmq_pkg.sv -----
// Package with the request and result types and shared constants of the quaternion block.
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;

  localparam logic [1:0] SEL_W = 2'd0;
  localparam logic [1:0] SEL_X = 2'd1;
  localparam logic [1:0] SEL_Y = 2'd2;
  localparam logic [1:0] SEL_Z = 2'd3;

  typedef struct packed {
    logic signed [15:0] rot_00;
    logic signed [15:0] rot_01;
    logic signed [15:0] rot_02;
    logic signed [15:0] rot_10;
    logic signed [15:0] rot_11;
    logic signed [15:0] rot_12;
    logic signed [15:0] rot_20;
    logic signed [15:0] rot_21;
    logic signed [15:0] rot_22;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } req_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] out_trans_x;
    logic signed [31:0] out_trans_y;
    logic signed [31:0] out_trans_z;
    logic [1:0]         branch_case;
    logic               divide_fault;
  } res_t;

endpackage

// ----- src/rmq_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with clamping and saturation.
module rmq_div #(
  parameter int NW = 32,
  parameter int DW = 18
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [NW-1:0]       num,
  input  logic [DW-1:0]       den,
  input  logic                neg,
  output logic signed [15:0]  quot
);
  // Stage arrays: partial remainder, divisor, quotient bits, sign.
  logic [DW:0]   rem  [NW+1];
  logic [NW-1:0] nsh  [NW+1];
  logic [DW-1:0] dv   [NW+1];
  logic          sg   [NW+1];
  logic          vl   [NW+1];
  logic [NW-1:0] q;
  logic [NW:0]   qc;
  logic signed [17:0] sq;

  assign rem[0] = '0;
  assign nsh[0] = num;
  assign dv[0]  = den;
  assign sg[0]  = neg;
  assign vl[0]  = in_valid;

  // One restoring step per register stage; quotient bits shift into nsh.
  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    assign sh = {rem[i], nsh[i][NW-1]};
    assign df = sh - {2'b00, dv[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else begin
        vl[i+1] <= vl[i];
      end
      dv[i+1] <= dv[i];
      sg[i+1] <= sg[i];
      if (!df[DW+1]) begin
        rem[i+1] <= df[DW:0];
        nsh[i+1] <= {nsh[i][NW-2:0], 1'b1};
      end else begin
        rem[i+1] <= sh[DW:0];
        nsh[i+1] <= {nsh[i][NW-2:0], 1'b0};
      end
    end
  end

  // Clamp to 65536, apply sign, then saturate.
  always_comb begin
    q  = nsh[NW];
    qc = {1'b0, q};
    if (qc > (NW+1)'(65536)) qc = (NW+1)'(65536);
    sq = sg[NW] ? -$signed({1'b0, qc[16:0]}) : $signed({1'b0, qc[16:0]});
    if (sq > 18'sd32767) quot = 16'sh7fff;
    else if (sq < -18'sd32768) quot = 16'sh8000;
    else quot = sq[15:0];
  end
endmodule

// ----- src/rotation_matrix_to_quaternion_top.sv -----
// Top level of the rotation matrix to quaternion converter.
// Usage: drive req and pulse start; busy is always low, so a request is
// taken every cycle it is presented. Each request gives one result on res,
// marked by a one-cycle done strobe, in order.
// Path: a sum stage and a select stage, then SQW = 16 square root stages
// (one result bit per stage), then NW = 32 divider stages (one quotient bit
// per stage), then one output register. Throughput is one request per cycle.
// The divider chain of one stage per quotient bit sets the latency.
// Reset clears all valid bits; payload registers are not reset.
// The receiver cannot stall: done is a plain strobe and the result must be
// captured in the cycle it appears. Translation passes unchanged.
// A chosen sum that is zero or negative raises divide_fault and forces all
// four quaternion fields to the positive saturation value.
// The square root takes (FRAC_BITS+18)/2 rounded up stages.
module rotation_matrix_to_quaternion_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  rmq_pkg::req_t  req,
  output logic           done,
  output rmq_pkg::res_t  res
);
  import rmq_pkg::*;

  localparam int FRAC_BITS = FRAC_BITS_DEF;
  localparam int RW  = FRAC_BITS + 18;       // radicand width
  localparam int SQW = (RW + 1) / 2;         // root width
  localparam int NW  = 18 + FRAC_BITS;       // numerator width
  localparam int DW  = SQW + 1;              // divisor width (2*s)

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic [1:0]         sel;
    logic               fault;
    logic [2:0][17:0]   n;   // signed numerators in order of non-chosen slots
  } side_t;

  assign busy = 1'b0;

  // Stage 1: diagonal sums and numerators.
  logic               v1;
  logic signed [18:0] d1 [4];
  logic signed [17:0] nm1 [4][3];
  req_t               r1;
  logic signed [18:0] one_c;
  assign one_c = 19'sd1 <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    r1 <= req;
    d1[0] <= one_c + req.rot_00 + req.rot_11 + req.rot_22;
    d1[1] <= one_c + req.rot_00 - req.rot_11 - req.rot_22;
    d1[2] <= one_c - req.rot_00 + req.rot_11 - req.rot_22;
    d1[3] <= one_c - req.rot_00 - req.rot_11 + req.rot_22;
    nm1[0][0] <= 18'(req.rot_21 - req.rot_12);
    nm1[0][1] <= 18'(req.rot_02 - req.rot_20);
    nm1[0][2] <= 18'(req.rot_10 - req.rot_01);
    nm1[1][0] <= 18'(req.rot_21 - req.rot_12);
    nm1[1][1] <= 18'(req.rot_10 + req.rot_01);
    nm1[1][2] <= 18'(req.rot_02 + req.rot_20);
    nm1[2][0] <= 18'(req.rot_02 - req.rot_20);
    nm1[2][1] <= 18'(req.rot_10 + req.rot_01);
    nm1[2][2] <= 18'(req.rot_21 + req.rot_12);
    nm1[3][0] <= 18'(req.rot_10 - req.rot_01);
    nm1[3][1] <= 18'(req.rot_02 + req.rot_20);
    nm1[3][2] <= 18'(req.rot_21 + req.rot_12);
  end

  // Stage 2: pick largest sum, earliest wins ties.
  logic [1:0]         sel_c;
  logic signed [18:0] best_c;
  always_comb begin
    sel_c  = SEL_W;
    best_c = d1[0];
    if (d1[1] > best_c) begin sel_c = SEL_X; best_c = d1[1]; end
    if (d1[2] > best_c) begin sel_c = SEL_Y; best_c = d1[2]; end
    if (d1[3] > best_c) begin sel_c = SEL_Z; best_c = d1[3]; end
  end

  logic          v2;
  side_t         s2;
  logic [RW-1:0] rad2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    s2.tx    <= r1.trans_x;
    s2.ty    <= r1.trans_y;
    s2.tz    <= r1.trans_z;
    s2.sel   <= sel_c;
    s2.fault <= (best_c <= 19'sd0);
    s2.n[0]  <= nm1[sel_c][0];
    s2.n[1]  <= nm1[sel_c][1];
    s2.n[2]  <= nm1[sel_c][2];
    rad2     <= (best_c <= 19'sd0) ? '0 : RW'({best_c[17:0], {FRAC_BITS{1'b0}}});
  end

  // Square root: one result bit per stage, digit-by-digit.
  logic [RW+1:0] rrem [SQW+1];
  logic [SQW-1:0] root [SQW+1];
  logic [2*SQW-1:0] rrad [SQW+1];
  side_t         rs   [SQW+1];
  logic          rv   [SQW+1];
  assign rrem[0] = '0;
  assign root[0] = '0;
  assign rrad[0] = (2*SQW)'(rad2);
  assign rs[0]   = s2;
  assign rv[0]   = v2;
  for (genvar i = 0; i < SQW; i++) begin : g_sq
    logic [RW+1:0] tr;
    logic [RW+1:0] tt;
    assign tr = {rrem[i][RW-1:0], rrad[i][2*SQW-1 -: 2]};
    assign tt = (RW+2)'({root[i], 2'b01});
    always_ff @(posedge clk) begin
      if (rst) rv[i+1] <= 1'b0;
      else rv[i+1] <= rv[i];
      rs[i+1]   <= rs[i];
      rrad[i+1] <= rrad[i] << 2;
      if (tr >= tt) begin
        rrem[i+1] <= tr - tt;
        root[i+1] <= {root[i][SQW-2:0], 1'b1};
      end else begin
        rrem[i+1] <= tr;
        root[i+1] <= {root[i][SQW-2:0], 1'b0};
      end
    end
  end

  // Divider inputs: numerator magnitude << FRAC_BITS plus s, divisor 2*s.
  logic [SQW-1:0] s_r;
  side_t          sd;
  logic [NW-1:0]  dnum [3];
  logic           dneg [3];
  logic [DW-1:0]  dden;
  assign s_r  = root[SQW];
  assign sd   = rs[SQW];
  assign dden = {s_r, 1'b0};
  for (genvar j = 0; j < 3; j++) begin : g_dn
    logic [17:0] mag;
    assign dneg[j] = sd.n[j][17];
    assign mag     = dneg[j] ? 18'(-sd.n[j]) : sd.n[j];
    assign dnum[j] = NW'({mag, {FRAC_BITS{1'b0}}}) + NW'(s_r);
  end

  logic signed [15:0] dq [3];
  for (genvar j = 0; j < 3; j++) begin : g_div
    rmq_div #(.NW(NW), .DW(DW)) u_div (
      .clk(clk), .rst(rst), .in_valid(rv[SQW]),
      .num(dnum[j]), .den(dden), .neg(dneg[j]), .quot(dq[j])
    );
  end

  // Side data and chosen component travel alongside the divider.
  side_t          ps [NW+1];
  logic [15:0]    pc [NW+1];
  logic           pv [NW+1];
  logic [SQW:0]   chs;
  assign chs   = ({1'b0, s_r} + 1'b1) >> 1;
  assign ps[0] = sd;
  assign pc[0] = (chs > (SQW+1)'(32767)) ? 16'h7fff : 16'(chs);
  assign pv[0] = rv[SQW];
  for (genvar i = 0; i < NW; i++) begin : g_sd
    always_ff @(posedge clk) begin
      if (rst) pv[i+1] <= 1'b0;
      else pv[i+1] <= pv[i];
      ps[i+1] <= ps[i];
      pc[i+1] <= pc[i];
    end
  end

  // Output register: place components by chosen case.
  side_t sf;
  logic signed [15:0] qo [4];
  assign sf = ps[NW];
  always_comb begin
    case (sf.sel)
      SEL_W: begin qo[0]=pc[NW]; qo[1]=dq[0]; qo[2]=dq[1]; qo[3]=dq[2]; end
      SEL_X: begin qo[0]=dq[0]; qo[1]=pc[NW]; qo[2]=dq[1]; qo[3]=dq[2]; end
      SEL_Y: begin qo[0]=dq[0]; qo[1]=dq[1]; qo[2]=pc[NW]; qo[3]=dq[2]; end
      default: begin qo[0]=dq[0]; qo[1]=dq[1]; qo[2]=dq[2]; qo[3]=pc[NW]; end
    endcase
    if (sf.fault) begin
      qo[0] = 16'sh7fff; qo[1] = 16'sh7fff; qo[2] = 16'sh7fff; qo[3] = 16'sh7fff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= pv[NW];
    res.quat_w       <= qo[0];
    res.quat_x       <= qo[1];
    res.quat_y       <= qo[2];
    res.quat_z       <= qo[3];
    res.out_trans_x  <= sf.tx;
    res.out_trans_y  <= sf.ty;
    res.out_trans_z  <= sf.tz;
    res.branch_case  <= sf.sel;
    res.divide_fault <= sf.fault;
  end
endmodule

// ----- src/rmq_checker.sv -----
// Port-level checker for the quaternion converter, bound to the top level.
module rmq_checker (
  input logic          clk,
  input logic          rst,
  input logic          busy,
  input logic          done,
  input rmq_pkg::res_t res
);
  import rmq_pkg::*;

  a_busy_low: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_fault_sat: assert property (@(posedge clk) disable iff (rst)
    done && res.divide_fault |-> res.quat_w == 16'sh7fff && res.quat_x == 16'sh7fff)
    else $error("fault result not saturated");
  a_no_done_after_rst: assert property (@(posedge clk) !rst && $past(rst) |-> !done)
    else $error("result right after reset");
  a_chosen_nonneg: assert property (@(posedge clk) disable iff (rst)
    done && !res.divide_fault && res.branch_case == SEL_W |-> !res.quat_w[15])
    else $error("chosen component negative");
endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .res(res)
);
